@@ rtl/tbc_pkg.sv @@
// Shared types and constants of the translated block cache.
// Command and status bundles between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package tbc_pkg;

	// Link index width and the "no link" marker
	localparam int LINK_W = 7;
	localparam logic [LINK_W-1:0] LNONE = 7'h7F;

	// Operation codes of an input item
	typedef enum logic [2:0] {
		OP_LOOKUP = 3'd0,
		OP_INSERT = 3'd1,
		OP_MARK   = 3'd2,
		OP_LINK   = 3'd3,
		OP_STORE  = 3'd4,
		OP_WIPE   = 3'd5
	} op_t;

	// Cache entry state
	typedef enum logic [1:0] {
		ENT_EMPTY   = 2'd0,
		ENT_CODE    = 2'd1,
		ENT_REFUSED = 2'd2
	} ent_t;

	// Entry memory address source
	typedef enum logic [2:0] {
		ADR_IN    = 3'd0,
		ADR_PC    = 3'd1,
		ADR_SWEEP = 3'd2,
		ADR_CLR   = 3'd3,
		ADR_MARK  = 3'd4
	} addr_sel_t;

	// Record used by a closing transfer
	typedef enum logic [1:0] {
		REC_NONE   = 2'd0,
		REC_LOOKUP = 2'd1,
		REC_LINK   = 2'd2
	} rec_sel_t;

	// One result item
	typedef struct packed {
		logic        hit;
		logic        refused;
		logic [31:0] found_handle;
		logic        link_accepted;
		logic        patch_valid;
		logic [31:0] patch_site;
		logic        patch_to_code;
		logic [31:0] patch_handle;
	} res_t;

	// Controller to datapath
	typedef struct packed {
		logic      accept;
		logic      wipe_regs;
		addr_sel_t addr_sel;
		logic      link_cur;
		logic      clr_step;
		logic      ins_do;
		logic      link_commit;
		logic      walk_em;
		logic      mark_init;
		logic      mark_step;
		logic      st_start;
		logic      sw_chk;
		logic      sw_done;
		logic      finish;
		rec_sel_t  rec_sel;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
		logic walk_more;
		logic mark_more;
		logic bit_set;
		logic sweep_more;
		logic sweep_hit;
		logic clr_last;
	} sts_t;

endpackage

@@ rtl/tbc_ctrl.sv @@
// Controller state machine of the translated block cache.
// Depends on tbc_pkg; drives the datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps

module tbc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic [2:0]      operation,
	output logic            item_ready,
	output tbc_pkg::cmd_t   cmd,
	input  tbc_pkg::sts_t   sts
);

	typedef enum logic [12:0] {
		S_CLR     = 13'b0000000000001,
		S_IDLE    = 13'b0000000000010,
		S_LOOKUP  = 13'b0000000000100,
		S_INS     = 13'b0000000001000,
		S_LINK    = 13'b0000000010000,
		S_MARK0   = 13'b0000000100000,
		S_MARK    = 13'b0000001000000,
		S_STORE   = 13'b0000010000000,
		S_SW_RD   = 13'b0000100000000,
		S_SW_CHK  = 13'b0001000000000,
		S_WALK_RD = 13'b0010000000000,
		S_WALK_EM = 13'b0100000000000,
		S_FIN     = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   sweep_q, sweep_d;
	logic   wipe_q, wipe_d;

	assign item_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		cmd          = '0;
		cmd.addr_sel = tbc_pkg::ADR_PC;
		cmd.rec_sel  = tbc_pkg::REC_NONE;
		state_d      = state_q;
		sweep_d      = sweep_q;
		wipe_d       = wipe_q;
		case (state_q)
			S_CLR: begin
				cmd.addr_sel = tbc_pkg::ADR_CLR;
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = wipe_q ? S_FIN : S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.addr_sel = tbc_pkg::ADR_IN;
				if (item_valid) begin
					cmd.accept = 1'b1;
					sweep_d    = 1'b0;
					wipe_d     = 1'b0;
					case (tbc_pkg::op_t'(operation))
						tbc_pkg::OP_LOOKUP: state_d = S_LOOKUP;
						tbc_pkg::OP_INSERT: state_d = S_INS;
						tbc_pkg::OP_MARK:   state_d = S_MARK0;
						tbc_pkg::OP_LINK:   state_d = S_LINK;
						tbc_pkg::OP_STORE: begin
							sweep_d = 1'b1;
							state_d = S_STORE;
						end
						tbc_pkg::OP_WIPE: begin
							cmd.wipe_regs = 1'b1;
							wipe_d        = 1'b1;
							state_d       = S_CLR;
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_LOOKUP: begin
				if (sts.out_free) begin
					cmd.finish  = 1'b1;
					cmd.rec_sel = tbc_pkg::REC_LOOKUP;
					state_d     = S_IDLE;
				end
			end
			S_LINK: begin
				if (sts.out_free) begin
					cmd.link_commit = 1'b1;
					cmd.finish      = 1'b1;
					cmd.rec_sel     = tbc_pkg::REC_LINK;
					state_d         = S_IDLE;
				end
			end
			S_INS: begin
				cmd.ins_do = 1'b1;
				state_d    = S_WALK_RD;
			end
			S_WALK_RD: begin
				cmd.link_cur = 1'b1;
				if (sts.walk_more) begin
					state_d = S_WALK_EM;
				end else begin
					state_d = sweep_q ? S_SW_RD : S_FIN;
				end
			end
			S_WALK_EM: begin
				cmd.link_cur = 1'b1;
				if (sts.out_free) begin
					cmd.walk_em = 1'b1;
					state_d     = S_WALK_RD;
				end
			end
			S_MARK0: begin
				cmd.mark_init = 1'b1;
				state_d       = S_MARK;
			end
			S_MARK: begin
				cmd.addr_sel = tbc_pkg::ADR_MARK;
				if (sts.mark_more) begin
					cmd.mark_step = 1'b1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_STORE: begin
				if (sts.bit_set) begin
					cmd.st_start = 1'b1;
					state_d      = S_SW_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SW_RD: begin
				if (sts.sweep_more) begin
					cmd.addr_sel = tbc_pkg::ADR_SWEEP;
					state_d      = S_SW_CHK;
				end else begin
					cmd.sw_done = 1'b1;
					state_d     = S_FIN;
				end
			end
			S_SW_CHK: begin
				cmd.addr_sel = tbc_pkg::ADR_SWEEP;
				cmd.sw_chk   = 1'b1;
				state_d      = sts.sweep_hit ? S_WALK_RD : S_SW_RD;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State registers; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			sweep_q <= 1'b0;
			wipe_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			wipe_q  <= wipe_d;
		end
	end

endmodule

@@ rtl/tbc_dp.sv @@
// Datapath of the translated block cache: entry, link and bitmap memories,
// walk and sweep counters, result staging. Depends on tbc_pkg.
`timescale 1ns / 1ps

module tbc_dp #(
	parameter int ADDR_BITS   = 16,
	parameter int LINK_POOL   = 64,
	parameter int HANDLE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   guest_address,
	input  logic          code_present,
	input  logic [31:0]   code_handle,
	input  logic [16:0]   end_address,
	input  logic [31:0]   site_offset,
	output logic          result_valid,
	input  logic          result_ready,
	output logic          hit,
	output logic          refused,
	output logic [31:0]   found_handle,
	output logic          link_accepted,
	output logic          patch_valid,
	output logic [31:0]   patch_site,
	output logic          patch_to_code,
	output logic [31:0]   patch_handle,
	output logic          last,
	input  tbc_pkg::cmd_t cmd,
	output tbc_pkg::sts_t sts
);

	localparam int NSLOTS = 1 << ADDR_BITS;
	localparam int LI     = $clog2(LINK_POOL);
	localparam int LW     = tbc_pkg::LINK_W;
	localparam int SPW    = ADDR_BITS + 1;
	localparam int GW     = (ADDR_BITS > 16) ? ADDR_BITS : 16;
	localparam int EW     = (ADDR_BITS > 17) ? ADDR_BITS : 17;
	localparam int HW     = (HANDLE_BITS > 32) ? HANDLE_BITS : 32;
	localparam logic [LW-1:0] POOL = LW'(LINK_POOL);

	// Latched item
	logic [ADDR_BITS-1:0]   pc_q;
	logic                   present_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [16:0]            endv_q;
	logic [31:0]            site_q;

	// Control registers
	logic [ADDR_BITS-1:0] clr_q, k_q, longest_q, last_len_q;
	logic [16:0]          a_q;
	logic [LW-1:0]        cur_q, steps_q, pool_used_q, free_head_q, res_cnt_q;
	logic                 unlink_q;

	// Result staging
	tbc_pkg::res_t pend_q, res_q, rec, patch;
	logic          pend_v_q, res_valid_q, last_q, out_free;

	// Memories and their read registers
	tbc_pkg::ent_t          tag_mem [NSLOTS];
	logic [SPW-1:0]         span_mem [NSLOTS];
	logic [HANDLE_BITS-1:0] hnd_mem [NSLOTS];
	logic [LW-1:0]          head_mem [NSLOTS];
	logic                   bit_mem [NSLOTS];
	logic [31:0]            site_mem [LINK_POOL];
	logic [LW-1:0]          next_mem [LINK_POOL];

	tbc_pkg::ent_t          tag_rd_q;
	logic [SPW-1:0]         span_rd_q;
	logic [HANDLE_BITS-1:0] hnd_rd_q;
	logic [LW-1:0]          head_rd_q;
	logic                   bit_rd_q;
	logic [31:0]            site_rd_q;
	logic [LW-1:0]          next_rd_q;

	// Widening helpers
	logic [GW-1:0]          ga_w;
	logic [ADDR_BITS-1:0]   in_pc, addr, a_idx;
	logic [EW-1:0]          a_w, diff_w, pc_w;
	logic [ADDR_BITS-1:0]   bytes;
	logic [HW-1:0]          hin_w, hrd_w, hq_w;
	logic [HANDLE_BITS-1:0] in_handle;
	logic [31:0]            found32, item32;

	// Entry memory write controls
	logic                   tag_we, span_we, hnd_we, head_we, bit_we;
	tbc_pkg::ent_t          tag_wd;
	logic [SPW-1:0]         span_wd;
	logic [LW-1:0]          head_wd;
	logic                   bit_wd;

	// Link pool controls
	logic                   fh_ok, pu_ok, link_ok;
	logic [LW-1:0]          new_i, nx_clip;
	logic [LI-1:0]          link_rd_idx, next_wa;
	logic                   next_we, sweep_hit;
	logic [LW-1:0]          next_wd;

	assign ga_w      = GW'(guest_address);
	assign in_pc     = ga_w[ADDR_BITS-1:0];
	assign hin_w     = HW'(code_handle);
	assign in_handle = hin_w[HANDLE_BITS-1:0];
	assign hrd_w     = HW'(hnd_rd_q);
	assign found32   = hrd_w[31:0];
	assign hq_w      = HW'(handle_q);
	assign item32    = hq_w[31:0];
	assign a_w       = EW'(a_q);
	assign a_idx     = a_w[ADDR_BITS-1:0];
	assign pc_w      = EW'(pc_q);
	assign diff_w    = EW'(endv_q) - pc_w;
	assign bytes     = diff_w[ADDR_BITS-1:0];

	// Entry address select
	always_comb begin
		case (cmd.addr_sel)
			tbc_pkg::ADR_IN:    addr = in_pc;
			tbc_pkg::ADR_PC:    addr = pc_q;
			tbc_pkg::ADR_SWEEP: addr = pc_q - k_q;
			tbc_pkg::ADR_CLR:   addr = clr_q;
			tbc_pkg::ADR_MARK:  addr = a_idx;
			default:            addr = pc_q;
		endcase
	end

	// Link allocation: free list first, then fresh records
	assign fh_ok   = free_head_q < POOL;
	assign pu_ok   = pool_used_q < POOL;
	assign link_ok = fh_ok || pu_ok;
	assign new_i   = fh_ok ? free_head_q : pool_used_q;
	assign nx_clip = (next_rd_q < POOL) ? next_rd_q : tbc_pkg::LNONE;

	assign sweep_hit = (tag_rd_q != tbc_pkg::ENT_EMPTY) && ({1'b0, k_q} < span_rd_q);

	// Entry memory writes
	always_comb begin
		tag_we  = 1'b0;
		tag_wd  = tbc_pkg::ENT_EMPTY;
		span_we = cmd.ins_do;
		span_wd = present_q ? {1'b0, last_len_q} : '1;
		hnd_we  = cmd.ins_do;
		head_we = 1'b0;
		head_wd = tbc_pkg::LNONE;
		bit_we  = 1'b0;
		bit_wd  = 1'b0;
		if (cmd.ins_do) begin
			tag_we  = 1'b1;
			tag_wd  = present_q ? tbc_pkg::ENT_CODE : tbc_pkg::ENT_REFUSED;
			head_we = !present_q;
		end
		if (cmd.sw_chk && sweep_hit) begin
			tag_we  = 1'b1;
			head_we = 1'b1;
		end
		if (cmd.clr_step) begin
			tag_we  = 1'b1;
			head_we = 1'b1;
			bit_we  = 1'b1;
		end
		if (cmd.link_commit && link_ok) begin
			head_we = 1'b1;
			head_wd = new_i;
		end
		if (cmd.mark_step) begin
			bit_we = 1'b1;
			bit_wd = 1'b1;
		end
		if (cmd.sw_done) begin
			bit_we = 1'b1;
		end
	end

	// Entry memories
	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[addr] <= tag_wd;
		if (span_we) span_mem[addr] <= span_wd;
		if (hnd_we) hnd_mem[addr] <= present_q ? handle_q : '0;
		if (head_we) head_mem[addr] <= head_wd;
		if (bit_we) bit_mem[addr] <= bit_wd;
		tag_rd_q  <= tag_mem[addr];
		span_rd_q <= span_mem[addr];
		hnd_rd_q  <= hnd_mem[addr];
		head_rd_q <= head_mem[addr];
		bit_rd_q  <= bit_mem[addr];
	end

	// Link pool memories
	assign link_rd_idx = cmd.link_cur ? cur_q[LI-1:0] : free_head_q[LI-1:0];
	assign next_we     = (cmd.link_commit && link_ok) || (cmd.walk_em && unlink_q);
	assign next_wa     = cmd.link_commit ? new_i[LI-1:0] : cur_q[LI-1:0];
	assign next_wd     = cmd.link_commit ? head_rd_q : free_head_q;

	always_ff @(posedge clk) begin
		if (cmd.link_commit && link_ok) site_mem[new_i[LI-1:0]] <= site_q;
		if (next_we) next_mem[next_wa] <= next_wd;
		site_rd_q <= site_mem[link_rd_idx];
		next_rd_q <= next_mem[link_rd_idx];
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pc_q      <= in_pc;
			present_q <= code_present;
			handle_q  <= in_handle;
			endv_q    <= end_address;
			site_q    <= site_offset;
		end
	end

	// Counters, pool and length registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			k_q         <= '0;
			a_q         <= '0;
			cur_q       <= tbc_pkg::LNONE;
			steps_q     <= '0;
			unlink_q    <= 1'b0;
			pool_used_q <= '0;
			free_head_q <= tbc_pkg::LNONE;
			longest_q   <= '0;
			last_len_q  <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.wipe_regs) begin
				pool_used_q <= '0;
				free_head_q <= tbc_pkg::LNONE;
				longest_q   <= '0;
			end
			if (cmd.mark_init) begin
				if (bytes > longest_q) longest_q <= bytes;
				last_len_q <= bytes;
				a_q        <= pc_w[16:0];
			end
			if (cmd.mark_step) a_q <= a_q + 17'd1;
			if (cmd.st_start) k_q <= '0;
			if (cmd.sw_chk) begin
				k_q <= k_q + 1'b1;
				if (sweep_hit) begin
					cur_q    <= head_rd_q;
					steps_q  <= '0;
					unlink_q <= 1'b1;
				end
			end
			if (cmd.ins_do) begin
				cur_q    <= head_rd_q;
				steps_q  <= '0;
				unlink_q <= !present_q;
			end
			if (cmd.link_commit) begin
				if (fh_ok) begin
					free_head_q <= nx_clip;
				end else if (pu_ok) begin
					pool_used_q <= pool_used_q + 1'b1;
				end
			end
			if (cmd.walk_em) begin
				cur_q   <= next_rd_q;
				steps_q <= steps_q + 1'b1;
				if (unlink_q) free_head_q <= cur_q;
			end
		end
	end

	// Closing record and patch record
	always_comb begin
		rec = '0;
		case (cmd.rec_sel)
			tbc_pkg::REC_LOOKUP: begin
				case (tag_rd_q)
					tbc_pkg::ENT_CODE: begin
						rec.hit          = 1'b1;
						rec.found_handle = found32;
					end
					tbc_pkg::ENT_REFUSED: begin
						rec.hit          = 1'b1;
						rec.refused      = 1'b1;
						rec.found_handle = found32;
					end
					default: rec.hit = 1'b0;
				endcase
			end
			tbc_pkg::REC_LINK: rec.link_accepted = link_ok;
			default: rec.hit = 1'b0;
		endcase
		patch               = '0;
		patch.patch_valid   = 1'b1;
		patch.patch_site    = site_rd_q;
		patch.patch_to_code = !unlink_q;
		patch.patch_handle  = unlink_q ? 32'd0 : item32;
	end

	assign out_free = !res_valid_q || result_ready;

	// Result staging: one pending record so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
			res_cnt_q   <= '0;
		end else begin
			if (res_valid_q && result_ready) res_valid_q <= 1'b0;
			if (cmd.accept) begin
				pend_v_q  <= 1'b0;
				res_cnt_q <= '0;
			end
			if (cmd.walk_em && (res_cnt_q < POOL)) begin
				if (pend_v_q) res_valid_q <= 1'b1;
				pend_v_q  <= 1'b1;
				res_cnt_q <= res_cnt_q + 1'b1;
			end
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
				pend_v_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_em && (res_cnt_q < POOL)) begin
			pend_q <= patch;
			if (pend_v_q) begin
				res_q  <= pend_q;
				last_q <= 1'b0;
			end
		end
		if (cmd.finish) begin
			res_q  <= pend_v_q ? pend_q : rec;
			last_q <= 1'b1;
		end
	end

	// Status to the controller
	assign sts.out_free   = out_free;
	assign sts.walk_more  = (cur_q < POOL) && (steps_q < POOL);
	assign sts.mark_more  = a_q < endv_q;
	assign sts.bit_set    = bit_rd_q;
	assign sts.sweep_more = k_q < longest_q;
	assign sts.sweep_hit  = sweep_hit;
	assign sts.clr_last   = (clr_q == '1);

	assign result_valid  = res_valid_q;
	assign hit           = res_q.hit;
	assign refused       = res_q.refused;
	assign found_handle  = res_q.found_handle;
	assign link_accepted = res_q.link_accepted;
	assign patch_valid   = res_q.patch_valid;
	assign patch_site    = res_q.patch_site;
	assign patch_to_code = res_q.patch_to_code;
	assign patch_handle  = res_q.patch_handle;
	assign last          = last_q;

endmodule

@@ rtl/translated_block_cache_smc.sv @@
// Channel  Handshake                   Payload
// item     item_valid / item_ready     operation, guest_address, code_present,
//                                      code_handle, end_address, site_offset
// result   result_valid / result_ready hit, refused, found_handle, link_accepted,
//                                      patch_valid, patch_site, patch_to_code,
//                                      patch_handle, last
//
// Lookup, record link and unknown codes accept the item, then read the entry memory
// once before the result. Insert writes the entry, then walks each linked jump site;
// mark steps once per byte; a store to an unmarked byte only returns a result, else it
// sweeps every byte of the longest-block window, clears each hit entry and unlinks its sites.
// After reset, and for a wipe, a clearing pass steps through all 2**ADDR_BITS entries
// with item_ready low. A stalled result holds the sequencer at the next transfer.
// Top level; depends on tbc_pkg, tbc_ctrl and tbc_dp.
`timescale 1ns / 1ps

module translated_block_cache_smc #(
	parameter int ADDR_BITS   = 16,
	parameter int LINK_POOL   = 64,
	parameter int HANDLE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  operation,
	input  logic [15:0] guest_address,
	input  logic        code_present,
	input  logic [31:0] code_handle,
	input  logic [16:0] end_address,
	input  logic [31:0] site_offset,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        hit,
	output logic        refused,
	output logic [31:0] found_handle,
	output logic        link_accepted,
	output logic        patch_valid,
	output logic [31:0] patch_site,
	output logic        patch_to_code,
	output logic [31:0] patch_handle,
	output logic        last
);

	tbc_pkg::cmd_t cmd;
	tbc_pkg::sts_t sts;

	// Sequencer
	tbc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.operation  (operation),
		.item_ready (item_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// Memories, counters and result staging
	tbc_dp #(
		.ADDR_BITS   (ADDR_BITS),
		.LINK_POOL   (LINK_POOL),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.guest_address (guest_address),
		.code_present  (code_present),
		.code_handle   (code_handle),
		.end_address   (end_address),
		.site_offset   (site_offset),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.hit           (hit),
		.refused       (refused),
		.found_handle  (found_handle),
		.link_accepted (link_accepted),
		.patch_valid   (patch_valid),
		.patch_site    (patch_site),
		.patch_to_code (patch_to_code),
		.patch_handle  (patch_handle),
		.last          (last),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

@@ verif/tb.sv @@
// Testbench of the translated block cache: directed, link pool, backpressure
// and random tests, checked against a cycle-free predictor of the cache.
// Depends on tbc_pkg and translated_block_cache_smc.
`timescale 1ns / 1ps

module tb;

	localparam int NSLOT = 65536;
	localparam int POOL = 64;
	localparam int MAX_PER_ITEM = 64;
	localparam logic [16:0] SPAN_ALL = 17'h1FFFF;
	// Codes the block does not decode
	localparam logic [2:0] OP_UNUSED_A = 3'd6;
	localparam logic [2:0] OP_UNUSED_B = 3'd7;

	typedef struct packed {
		logic        hit;
		logic        refused;
		logic [31:0] found_handle;
		logic        link_accepted;
		logic        patch_valid;
		logic [31:0] patch_site;
		logic        patch_to_code;
		logic [31:0] patch_handle;
		logic        last;
	} cache_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [2:0]  operation = '0;
	logic [15:0] guest_address = '0;
	logic        code_present = 1'b0;
	logic [31:0] code_handle = '0;
	logic [16:0] end_address = '0;
	logic [31:0] site_offset = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        hit, refused, link_accepted, patch_valid, patch_to_code, last;
	logic [31:0] found_handle, patch_site, patch_handle;

	translated_block_cache_smc u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.operation(operation), .guest_address(guest_address),
		.code_present(code_present), .code_handle(code_handle),
		.end_address(end_address), .site_offset(site_offset),
		.result_valid(result_valid), .result_ready(result_ready),
		.hit(hit), .refused(refused), .found_handle(found_handle),
		.link_accepted(link_accepted), .patch_valid(patch_valid),
		.patch_site(patch_site), .patch_to_code(patch_to_code),
		.patch_handle(patch_handle), .last(last)
	);

	always #5 clk = ~clk;

	// Predicted cache state
	tbc_pkg::ent_t slot_state [NSLOT];
	logic [16:0]   slot_span [NSLOT];
	logic [31:0]   slot_handle [NSLOT];
	logic [6:0]    slot_links [NSLOT];
	logic [31:0]   site_of [POOL];
	logic [6:0]    next_of [POOL];
	logic          code_bit [NSLOT];
	int            pool_used;
	logic [6:0]    free_head;
	logic [15:0]   longest_len;
	logic [15:0]   last_len;

	cache_res_t pending_results[$];
	int  item_results;
	int  fail_count = 0;
	bit  idling_on = 1'b1;
	int  hold_cycles = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic wipe_cache();
		for (int i = 0; i < NSLOT; i++) begin
			slot_state[i] = tbc_pkg::ENT_EMPTY;
			slot_links[i] = tbc_pkg::LNONE;
			code_bit[i] = 1'b0;
		end
		pool_used = 0;
		free_head = tbc_pkg::LNONE;
		longest_len = '0;
	endtask

	task automatic post_result(input logic h, input logic r, input logic [31:0] fh,
			input logic acc, input logic pv, input logic [31:0] ps,
			input logic tc, input logic [31:0] ph);
		cache_res_t res;
		if (item_results < MAX_PER_ITEM) begin
			res = '{h, r, fh, acc, pv, ps, tc, ph, 1'b0};
			pending_results.push_back(res);
			item_results++;
		end
	endtask

	// Walk the link chain of a pc; refused or cleared entries free the links
	task automatic repatch_sites(input logic [15:0] pc, input bit to_code,
			input logic [31:0] handle);
		logic [6:0] idx, nxt;
		int steps;
		idx = slot_links[pc];
		steps = 0;
		while (idx < POOL && steps < POOL) begin
			nxt = next_of[idx];
			post_result(0, 0, 0, 0, 1, site_of[idx], to_code, to_code ? handle : 32'd0);
			if (!to_code) begin
				next_of[idx] = free_head;
				free_head = idx;
			end
			idx = nxt;
			steps++;
		end
		if (!to_code)
			slot_links[pc] = tbc_pkg::LNONE;
	endtask

	task automatic predict_item(input logic [2:0] op, input logic [15:0] pc,
			input logic present, input logic [31:0] handle,
			input logic [16:0] endv, input logic [31:0] site);
		logic [15:0] len, p;
		logic [6:0] idx;
		cache_res_t tail;
		bit ok;
		item_results = 0;
		case (op)
			tbc_pkg::OP_LOOKUP: begin
				if (slot_state[pc] == tbc_pkg::ENT_CODE)
					post_result(1, 0, slot_handle[pc], 0, 0, 0, 0, 0);
				else if (slot_state[pc] == tbc_pkg::ENT_REFUSED)
					post_result(1, 1, slot_handle[pc], 0, 0, 0, 0, 0);
			end
			tbc_pkg::OP_INSERT: begin
				slot_state[pc] = present ? tbc_pkg::ENT_CODE : tbc_pkg::ENT_REFUSED;
				slot_span[pc] = present ? {1'b0, last_len} : SPAN_ALL;
				slot_handle[pc] = present ? handle : 32'd0;
				repatch_sites(pc, present, handle);
			end
			tbc_pkg::OP_MARK: begin
				len = endv[15:0] - pc;
				if (len > longest_len)
					longest_len = len;
				last_len = len;
				for (int a = pc; a < endv; a++)
					code_bit[a[15:0]] = 1'b1;
			end
			tbc_pkg::OP_LINK: begin
				ok = 1'b1;
				idx = '0;
				if (free_head < POOL) begin
					idx = free_head;
					free_head = next_of[idx];
					if (free_head >= POOL)
						free_head = tbc_pkg::LNONE;
				end else if (pool_used < POOL) begin
					idx = pool_used[6:0];
					pool_used++;
				end else begin
					ok = 1'b0;
				end
				if (ok) begin
					site_of[idx] = site;
					next_of[idx] = slot_links[pc];
					slot_links[pc] = idx;
				end
				post_result(0, 0, 0, ok, 0, 0, 0, 0);
			end
			tbc_pkg::OP_STORE: begin
				// Sweep back over the longest-block window
				if (code_bit[pc]) begin
					for (int k = 0; k < longest_len; k++) begin
						p = pc - k[15:0];
						if (slot_state[p] == tbc_pkg::ENT_EMPTY || k >= slot_span[p])
							continue;
						slot_state[p] = tbc_pkg::ENT_EMPTY;
						slot_handle[p] = '0;
						repatch_sites(p, 1'b0, 32'd0);
					end
					code_bit[pc] = 1'b0;
				end
			end
			tbc_pkg::OP_WIPE: wipe_cache();
			default: ;
		endcase
		if (item_results == 0)
			post_result(0, 0, 0, 0, 0, 0, 0, 0);
		tail = pending_results[$];
		tail.last = 1'b1;
		pending_results[$] = tail;
	endtask

	// Offer one item and hold it until the transfer
	task automatic send_item(input logic [2:0] op, input logic [15:0] pc,
			input logic present, input logic [31:0] handle,
			input logic [16:0] endv, input logic [31:0] site);
		if (idling_on && $urandom_range(0, 99) < 14) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		operation = op;
		guest_address = pc;
		code_present = present;
		code_handle = handle;
		end_address = endv;
		site_offset = site;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		predict_item(op, pc, present, handle, endv, site);
		@(negedge clk);
	endtask

	// Receiver stalls: a counted long hold-off or random short ones
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result_ready = 1'b0;
			hold_cycles--;
		end else begin
			result_ready = !(idling_on && $urandom_range(0, 99) < 14);
		end
	end

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// Check every result transfer against the oldest expectation
	always @(posedge clk) begin
		cache_res_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = pending_results.pop_front();
				compare_field("hit", hit, want.hit);
				compare_field("refused", refused, want.refused);
				compare_field("found_handle", found_handle, want.found_handle);
				compare_field("link_accepted", link_accepted, want.link_accepted);
				compare_field("patch_valid", patch_valid, want.patch_valid);
				compare_field("patch_site", patch_site, want.patch_site);
				compare_field("patch_to_code", patch_to_code, want.patch_to_code);
				compare_field("patch_handle", patch_handle, want.patch_handle);
				compare_field("last", last, want.last);
			end
		end
	end

	// Extremes, every operation, refusals, wrap marks, unknown codes
	task automatic test_directed();
		send_item(tbc_pkg::OP_LOOKUP, 16'h0000, 0, 0, 0, 0);
		send_item(tbc_pkg::OP_MARK, 16'hFFFA, 0, 0, 17'h10000, 0);
		send_item(tbc_pkg::OP_LINK, 16'hFFFC, 0, 0, 0, 32'hFFFF_FFFF);
		send_item(tbc_pkg::OP_LINK, 16'hFFFC, 0, 0, 0, 32'h0000_0001);
		send_item(tbc_pkg::OP_INSERT, 16'hFFFC, 1, 32'hFFFF_FFFF, 0, 0);
		send_item(tbc_pkg::OP_LOOKUP, 16'hFFFC, 0, 0, 0, 0);
		send_item(tbc_pkg::OP_INSERT, 16'hFFFA, 0, 32'h1234_5678, 0, 0);
		send_item(tbc_pkg::OP_LOOKUP, 16'hFFFA, 0, 0, 0, 0);
		send_item(tbc_pkg::OP_LINK, 16'hFFFA, 0, 0, 0, 32'hA5A5_5A5A);
		send_item(tbc_pkg::OP_INSERT, 16'hFFFA, 0, 0, 0, 0);
		send_item(tbc_pkg::OP_STORE, 16'h0100, 0, 0, 0, 0);
		send_item(tbc_pkg::OP_STORE, 16'hFFFD, 0, 0, 0, 0);
		send_item(tbc_pkg::OP_LOOKUP, 16'hFFFC, 0, 0, 0, 0);
		send_item(tbc_pkg::OP_LOOKUP, 16'hFFFA, 0, 0, 0, 0);
		send_item(OP_UNUSED_A, 16'hFFFF, 1, 32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF);
		send_item(OP_UNUSED_B, 16'h5555, 0, 0, 0, 0);
		// End below start: lengths wrap, no bits set, huge sweep window
		send_item(tbc_pkg::OP_MARK, 16'h0200, 0, 0, 17'h0210, 0);
		send_item(tbc_pkg::OP_INSERT, 16'h0204, 1, 32'h0BAD_F00D, 0, 0);
		send_item(tbc_pkg::OP_MARK, 16'h0100, 0, 0, 17'h0050, 0);
		send_item(tbc_pkg::OP_INSERT, 16'h0208, 1, 32'h0000_0042, 0, 0);
		send_item(tbc_pkg::OP_STORE, 16'h0209, 0, 0, 0, 0);
		send_item(tbc_pkg::OP_LOOKUP, 16'h0204, 0, 0, 0, 0);
		send_item(tbc_pkg::OP_WIPE, 16'h0000, 0, 0, 0, 0);
		send_item(tbc_pkg::OP_LOOKUP, 16'h0208, 0, 0, 0, 0);
	endtask

	// Fill the link records past their count, then repatch and free them
	task automatic test_pool_exhaust();
		for (int i = 0; i < POOL + 2; i++)
			send_item(tbc_pkg::OP_LINK, 16'h0300, 0, 0, 0, $urandom);
		send_item(tbc_pkg::OP_INSERT, 16'h0300, 1, $urandom, 0, 0);
		send_item(tbc_pkg::OP_INSERT, 16'h0300, 0, 0, 0, 0);
		send_item(tbc_pkg::OP_LINK, 16'h0301, 0, 0, 0, $urandom);
	endtask

	// Long receiver hold-off while items keep coming
	task automatic test_backpressure();
		hold_cycles = 400;
		for (int i = 0; i < 30; i++)
			send_item(i % 3 == 0 ? tbc_pkg::OP_LINK : tbc_pkg::OP_LOOKUP,
				16'h0300 + i[15:0], 0, 0, 0, $urandom);
	endtask

	task automatic test_random();
		logic [15:0] base, pc;
		logic [16:0] endv;
		int pick;
		logic [2:0] op;
		base = $urandom;
		for (int n = 0; n < 200; n++) begin
			if (n % 50 == 0)
				base = $urandom;
			idling_on = !(n >= 120 && n < 170);
			pc = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
				base + 16'($urandom_range(0, 31));
			endv = 17'($urandom_range(0, 65536));
			pick = $urandom_range(0, 99);
			if (n == 150) op = tbc_pkg::OP_WIPE;
			else if (pick < 30) op = tbc_pkg::OP_LOOKUP;
			else if (pick < 45) op = tbc_pkg::OP_INSERT;
			else if (pick < 60) begin
				op = tbc_pkg::OP_MARK;
				endv = 17'(pc) + 17'($urandom_range(0, 12));
				if (endv > 17'h10000)
					endv = 17'h10000;
			end
			else if (pick < 80) op = tbc_pkg::OP_LINK;
			else if (pick < 97) op = tbc_pkg::OP_STORE;
			else op = pick[0] ? OP_UNUSED_A : OP_UNUSED_B;
			send_item(op, pc, $urandom_range(0, 3) != 0, $urandom, endv, $urandom);
		end
	endtask

	initial begin
		wipe_cache();
		last_len = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_pool_exhaust();
		test_backpressure();
		test_random();
		item_valid = 1'b0;
		idling_on = 1'b1;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#40ms;
		$display("tb NOT OK");
		$finish;
	end

endmodule
